// ===== hdl/filled_triangle_scanline_core_defines.svh =====
// ----------------------------------------------------------------------------
// filled_triangle_scanline_core_defines
// assertion macros used by the rasteriser rtl
// ----------------------------------------------------------------------------
`ifndef FILLED_TRIANGLE_SCANLINE_CORE_DEFINES_SVH
`define FILLED_TRIANGLE_SCANLINE_CORE_DEFINES_SVH

// same-cycle implication
`define FTSC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ftsc assertion failed");

// next-cycle implication
`define FTSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ftsc assertion failed");

`endif

// ===== hdl/ftsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftsc_pkg
// shared codes and types of the triangle scanline rasteriser
// ----------------------------------------------------------------------------
package ftsc_pkg;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } ftsc_div_stat_t;

endpackage

// ===== hdl/ftsc_div.sv =====
// ----------------------------------------------------------------------------
// ftsc_div
// radix-2 restoring divider for edge slopes, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ftsc_div #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [COORD_BITS:0]            dx,
    input  logic        [COORD_BITS-1:0]          dy,
    output logic signed [COORD_BITS+FRAC_BITS:0]  slope,
    output ftsc_pkg::ftsc_div_stat_t              stat
);
    import ftsc_pkg::*;

    localparam int QW = COORD_BITS + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]         quo_reg;
    logic [COORD_BITS:0]   rem_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  neg_reg;
    logic                  zero_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [COORD_BITS-1:0] dx_mag;
    logic [COORD_BITS:0]   rem_shift;
    logic                  fits;

    assign dx_mag    = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign rem_shift = {rem_reg[COORD_BITS-1:0], quo_reg[QW-1]};
    assign fits      = rem_shift >= {1'b0, dy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= {dx_mag, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                dy_reg   <= dy;
                neg_reg  <= dx[COORD_BITS];
                zero_reg <= (dy == '0);
                cnt_reg  <= CW'(QW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_shift - {1'b0, dy_reg} : rem_shift;
                quo_reg <= {quo_reg[QW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (zero_reg) begin
            slope = '0;
        end else if (neg_reg) begin
            slope = -$signed({1'b0, quo_reg});
        end else begin
            slope = $signed({1'b0, quo_reg});
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/ftsc_edge_mac.sv =====
// ----------------------------------------------------------------------------
// ftsc_edge_mac
// shared edge evaluator: base x scaled plus row offset times slope, registered
// ----------------------------------------------------------------------------
module ftsc_edge_mac #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                    aclk,
    input  logic        [COORD_BITS-1:0]            base_x,
    input  logic        [COORD_BITS-1:0]            row_diff,
    input  logic signed [COORD_BITS+FRAC_BITS:0]    slope,
    output logic signed [COORD_BITS+FRAC_BITS+1:0]  edge_x
);
    import ftsc_pkg::*;

    localparam int XW = COORD_BITS + FRAC_BITS + 2;
    localparam int PW = COORD_BITS + 1 + COORD_BITS + FRAC_BITS + 1;

    logic signed [PW-1:0] prod;
    logic signed [XW-1:0] base_scaled;
    logic signed [XW-1:0] edge_x_reg;

    assign prod        = $signed({1'b0, row_diff}) * slope;
    assign base_scaled = $signed({2'b00, base_x, {FRAC_BITS{1'b0}}});

    always_ff @(posedge aclk) begin
        edge_x_reg <= base_scaled + prod[XW-1:0];
    end

    assign edge_x = edge_x_reg;

endmodule

// ===== hdl/filled_triangle_scanline_core.sv =====
// ----------------------------------------------------------------------------
// filled_triangle_scanline_core
// scanline rasteriser for one filled triangle, pixel per step beat
// ----------------------------------------------------------------------------
//  channel | dir | fields                                     | beat
//  s_      | in  | func, ax, ay, bx, by_coord, cx, cy, colour | load or step
//  m_      | out | pixel_x, pixel_y, pixel_color, has/last    | one per step
//
//  load: vertex sort, one divider run per edge, a side test at the mid row,
//  then a row evaluation per scanned row through the shared edge evaluator
//  step: a row evaluation per scanned row, then the finish; a row change costs a row evaluation
//  s_ready is low while a beat is in work; a stalled m_ beat holds the finish
//  synchronous active-low reset clears control state and the pending flag
// ----------------------------------------------------------------------------
`include "filled_triangle_scanline_core_defines.svh"

module filled_triangle_scanline_core #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [COORD_BITS-1:0] s_ax,
    input  logic [COORD_BITS-1:0] s_ay,
    input  logic [COORD_BITS-1:0] s_bx,
    input  logic [COORD_BITS-1:0] s_by_coord,
    input  logic [COORD_BITS-1:0] s_cx,
    input  logic [COORD_BITS-1:0] s_cy,
    input  logic [23:0]           s_fill_color,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [23:0]           m_pixel_color,
    output logic                  m_has_pixel,
    output logic                  m_last_pixel
);
    import ftsc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int SW = COORD_BITS + FRAC_BITS + 1;
    localparam int XW = COORD_BITS + FRAC_BITS + 2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SORT, ST_DIV_START, ST_DIV_WAIT,
        ST_ROW, ST_EVAL_L, ST_EVAL_S, ST_EVAL_DONE, ST_FINISH
    } state_t;

    state_t state_reg;

    logic [CB-1:0]        vx_reg [3];
    logic [CB-1:0]        vy_reg [3];
    logic signed [SW-1:0] slope_reg [3];
    logic [1:0]           idx_reg;
    logic                 lsl_reg;
    logic                 active_reg;
    logic                 mid_phase_reg;
    logic                 fresh_reg;
    logic                 found_reg;
    logic                 is_load_reg;
    logic                 res_has_reg;
    logic [CB-1:0]        row_reg;
    logic [CB-1:0]        eval_y_reg;
    logic [CB:0]          col_reg;
    logic [23:0]          color_reg;
    logic [CB-1:0]        res_x_reg;
    logic [CB-1:0]        res_y_reg;
    logic signed [XW-1:0] long_x_reg;

    logic                  m_valid_reg;
    logic [CB-1:0]         m_x_reg;
    logic [CB-1:0]         m_y_reg;
    logic [23:0]           m_color_reg;
    logic                  m_has_reg;
    logic                  m_last_reg;

    // sort pair and divider edge selection
    logic [1:0] pa, pb;
    always_comb begin
        unique case (idx_reg)
            2'd0:    begin pa = 2'd0; pb = 2'd1; end
            2'd1:    begin pa = 2'd0; pb = 2'd2; end
            default: begin pa = 2'd1; pb = 2'd2; end
        endcase
    end

    logic                 div_start;
    logic signed [CB:0]   div_dx;
    logic [CB-1:0]        div_dy;
    logic signed [SW-1:0] div_slope;
    ftsc_div_stat_t       div_stat;

    assign div_start = (state_reg == ST_DIV_START);
    assign div_dx    = $signed({1'b0, vx_reg[pb]}) - $signed({1'b0, vx_reg[pa]});
    assign div_dy    = vy_reg[pb] - vy_reg[pa];

    ftsc_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dx      (div_dx),
        .dy      (div_dy),
        .slope   (div_slope),
        .stat    (div_stat)
    );

    // edge evaluator operands: long edge in EVAL_L, short path in EVAL_S
    logic [CB-1:0]        mac_base;
    logic [CB-1:0]        mac_diff;
    logic signed [SW-1:0] mac_slope;
    logic signed [XW-1:0] mac_x;

    always_comb begin
        if (state_reg != ST_EVAL_S) begin
            mac_base  = vx_reg[0];
            mac_diff  = eval_y_reg - vy_reg[0];
            mac_slope = slope_reg[2];
        end else if (eval_y_reg < vy_reg[1]) begin
            mac_base  = vx_reg[0];
            mac_diff  = eval_y_reg - vy_reg[0];
            mac_slope = slope_reg[0];
        end else begin
            mac_base  = vx_reg[1];
            mac_diff  = eval_y_reg - vy_reg[1];
            mac_slope = slope_reg[1];
        end
    end

    ftsc_edge_mac #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk     (aclk),
        .base_x   (mac_base),
        .row_diff (mac_diff),
        .slope    (mac_slope),
        .edge_x   (mac_x)
    );

    logic signed [XW-1:0] lx, rx;
    logic [CB:0]          col_eff;
    logic                 hit;
    logic [CB-1:0]        mid_y;
    logic [CB:0]          span;
    logic                 emit;
    logic                 vy_sorted;

    assign lx      = lsl_reg ? long_x_reg : mac_x;
    assign rx      = lsl_reg ? mac_x : long_x_reg;
    assign col_eff = fresh_reg ? lx[FRAC_BITS+CB:FRAC_BITS] : col_reg;
    assign hit     = $signed({1'b0, col_eff, {FRAC_BITS{1'b0}}}) < rx;
    assign span    = {1'b0, vy_reg[2] - vy_reg[0]} + 1'b1;
    assign mid_y   = vy_reg[0] + span[CB:1];
    assign emit    = (state_reg == ST_FINISH) && !is_load_reg && (!m_valid_reg || m_ready);
    assign vy_sorted = (vy_reg[0] <= vy_reg[1]) && (vy_reg[1] <= vy_reg[2]);

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_func == FUNC_LOAD) begin
                            vx_reg[0]   <= s_ax;
                            vy_reg[0]   <= s_ay;
                            vx_reg[1]   <= s_bx;
                            vy_reg[1]   <= s_by_coord;
                            vx_reg[2]   <= s_cx;
                            vy_reg[2]   <= s_cy;
                            color_reg   <= s_fill_color;
                            is_load_reg <= 1'b1;
                            idx_reg     <= '0;
                            state_reg   <= ST_SORT;
                        end else if (active_reg) begin
                            is_load_reg <= 1'b0;
                            res_has_reg <= 1'b1;
                            res_x_reg   <= col_reg[CB-1:0];
                            res_y_reg   <= row_reg;
                            col_reg     <= col_reg + 1'b1;
                            fresh_reg   <= 1'b0;
                            state_reg   <= ST_ROW;
                        end else begin
                            is_load_reg <= 1'b0;
                            res_has_reg <= 1'b0;
                            found_reg   <= 1'b0;
                            state_reg   <= ST_FINISH;
                        end
                    end
                end
                ST_SORT: begin
                    if (vy_reg[pb] < vy_reg[pa]) begin
                        vx_reg[pa] <= vx_reg[pb];
                        vy_reg[pa] <= vy_reg[pb];
                        vx_reg[pb] <= vx_reg[pa];
                        vy_reg[pb] <= vy_reg[pa];
                    end
                    if (idx_reg == 2'd2) begin
                        idx_reg   <= '0;
                        state_reg <= ST_DIV_START;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_stat.done) begin
                        // pairs run v0-v1, v0-v2, v1-v2
                        unique case (idx_reg)
                            2'd0:    slope_reg[0] <= div_slope;
                            2'd1:    slope_reg[2] <= div_slope;
                            default: slope_reg[1] <= div_slope;
                        endcase
                        if (idx_reg == 2'd2) begin
                            idx_reg       <= '0;
                            eval_y_reg    <= mid_y;
                            mid_phase_reg <= 1'b1;
                            state_reg     <= ST_EVAL_L;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                ST_ROW: begin
                    if (row_reg >= vy_reg[2]) begin
                        found_reg <= 1'b0;
                        state_reg <= ST_FINISH;
                    end else begin
                        eval_y_reg <= row_reg;
                        state_reg  <= ST_EVAL_L;
                    end
                end
                ST_EVAL_L: begin
                    state_reg <= ST_EVAL_S;
                end
                ST_EVAL_S: begin
                    long_x_reg <= mac_x;
                    state_reg  <= ST_EVAL_DONE;
                end
                ST_EVAL_DONE: begin
                    if (mid_phase_reg) begin
                        lsl_reg       <= long_x_reg < mac_x;
                        mid_phase_reg <= 1'b0;
                        row_reg       <= vy_reg[0];
                        fresh_reg     <= 1'b1;
                        state_reg     <= ST_ROW;
                    end else if (hit) begin
                        col_reg   <= col_eff;
                        found_reg <= 1'b1;
                        state_reg <= ST_FINISH;
                    end else begin
                        row_reg   <= row_reg + 1'b1;
                        fresh_reg <= 1'b1;
                        state_reg <= ST_ROW;
                    end
                end
                ST_FINISH: begin
                    if (is_load_reg) begin
                        active_reg <= found_reg;
                        state_reg  <= ST_IDLE;
                    end else if (emit) begin
                        m_x_reg     <= res_has_reg ? res_x_reg : '0;
                        m_y_reg     <= res_has_reg ? res_y_reg : '0;
                        m_color_reg <= res_has_reg ? color_reg : '0;
                        m_has_reg   <= res_has_reg;
                        m_last_reg  <= res_has_reg && !found_reg;
                        active_reg  <= res_has_reg && found_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_x_reg;
    assign m_pixel_y     = m_y_reg;
    assign m_pixel_color = m_color_reg;
    assign m_has_pixel   = m_has_reg;
    assign m_last_pixel  = m_last_reg;

    `FTSC_ASSERT_NOW(a_empty_not_last, aclk, aresetn, m_valid && !m_has_pixel, !m_last_pixel)
    `FTSC_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_valid && s_ready, !s_ready)
    `FTSC_ASSERT_NOW(a_sorted_for_div, aclk, aresetn, state_reg == ST_DIV_START, vy_sorted)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the triangle scanline rasteriser: loads triangles, steps pixels and
// compares every m_ beat against a fixed-point scan predictor in the bench
// ----------------------------------------------------------------------------
import ftsc_pkg::*;

typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [23:0] colour;
    logic        has;
    logic        last;
} pixel_beat_t;

class raster_scoreboard;
    longint      vtx[6];
    longint      slope[3];
    longint      row_now;
    longint      col_now;
    bit          long_left;
    bit          pending;
    logic [23:0] colour;
    pixel_beat_t due_pixels[$];
    int          mismatches;

    function new();
        foreach (vtx[i]) vtx[i] = 0;
        foreach (slope[i]) slope[i] = 0;
        row_now = 0; col_now = 0; long_left = 0; pending = 0; colour = 0;
        mismatches = 0;
    endfunction

    function longint edge_slope(longint xa, longint ya, longint xb, longint yb);
        if (ya == yb) return 0;
        return ((xb - xa) * 65536) / (yb - ya);
    endfunction

    function longint long_edge_x(longint y);
        return vtx[0] * 65536 + (y - vtx[1]) * slope[2];
    endfunction

    function longint short_edge_x(longint y);
        if (y < vtx[3]) return vtx[0] * 65536 + (y - vtx[1]) * slope[0];
        return vtx[2] * 65536 + (y - vtx[3]) * slope[1];
    endfunction

    function bit find_pixel(longint row, longint col, bit fresh);
        longint lx, rx;
        while (1) begin
            if (row >= vtx[5]) return 0;
            lx = long_left ? long_edge_x(row) : short_edge_x(row);
            rx = long_left ? short_edge_x(row) : long_edge_x(row);
            if (fresh) col = lx / 65536;
            if (col * 65536 < rx) begin
                row_now = row;
                col_now = col;
                return 1;
            end
            row++;
            fresh = 1;
        end
    endfunction

    function void swap_vtx(int a, int b);
        longint tx, ty;
        tx = vtx[2*a]; ty = vtx[2*a+1];
        vtx[2*a] = vtx[2*b]; vtx[2*a+1] = vtx[2*b+1];
        vtx[2*b] = tx; vtx[2*b+1] = ty;
    endfunction

    function void note_beat(logic func, logic [9:0] ax, logic [9:0] ay, logic [9:0] bx,
                            logic [9:0] by, logic [9:0] cx, logic [9:0] cy,
                            logic [23:0] fill);
        pixel_beat_t p;
        longint mid;
        if (func == FUNC_LOAD) begin
            vtx[0] = longint'(ax); vtx[1] = longint'(ay); vtx[2] = longint'(bx);
            vtx[3] = longint'(by); vtx[4] = longint'(cx); vtx[5] = longint'(cy);
            colour = fill;
            if (vtx[3] < vtx[1]) swap_vtx(0, 1);
            if (vtx[5] < vtx[1]) swap_vtx(0, 2);
            if (vtx[5] < vtx[3]) swap_vtx(1, 2);
            slope[0] = edge_slope(vtx[0], vtx[1], vtx[2], vtx[3]);
            slope[1] = edge_slope(vtx[2], vtx[3], vtx[4], vtx[5]);
            slope[2] = edge_slope(vtx[0], vtx[1], vtx[4], vtx[5]);
            mid = vtx[1] + (vtx[5] - vtx[1] + 1) / 2;
            long_left = long_edge_x(mid) < short_edge_x(mid);
            pending = find_pixel(vtx[1], 0, 1);
            return;
        end
        if (!pending) begin
            p.x = '0; p.y = '0; p.colour = '0; p.has = 1'b0; p.last = 1'b0;
        end else begin
            p.x = col_now[9:0]; p.y = row_now[9:0]; p.colour = colour; p.has = 1'b1;
            pending = find_pixel(row_now, col_now + 1, 0);
            p.last = !pending;
        end
        due_pixels = {due_pixels, p};
    endfunction

    function void check_beat(pixel_beat_t got);
        pixel_beat_t exp;
        if (due_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected m_ beat x=%0d y=%0d", got.x, got.y);
            return;
        end
        exp = due_pixels.pop_front();
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp x=%0d y=%0d c=%h h=%b l=%b, %s",
                         exp.x, exp.y, exp.colour, exp.has, exp.last,
                         $sformatf("got x=%0d y=%0d c=%h h=%b l=%b",
                                   got.x, got.y, got.colour, got.has, got.last));
        end
    endfunction
endclass

module tb_top;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_func = FUNC_STEP;
    logic [9:0]  s_ax = 0, s_ay = 0, s_bx = 0, s_by_coord = 0, s_cx = 0, s_cy = 0;
    logic [23:0] s_fill_color = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [9:0]  m_pixel_x, m_pixel_y;
    logic [23:0] m_pixel_color;
    logic        m_has_pixel, m_last_pixel;

    raster_scoreboard scan_sb = new();
    bit          no_idle = 0;
    int          beats_sent = 0;
    int          quiet_cycles = 0;

    always #4 aclk = ~aclk;

    filled_triangle_scanline_core dut (.*);

    always @(negedge aclk) m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);

    always @(posedge aclk) begin
        pixel_beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got.x = m_pixel_x; got.y = m_pixel_y; got.colour = m_pixel_color;
            got.has = m_has_pixel; got.last = m_last_pixel;
            scan_sb.check_beat(got);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 40000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic send_beat(logic func, logic [9:0] ax, logic [9:0] ay, logic [9:0] bx,
                             logic [9:0] by, logic [9:0] cx, logic [9:0] cy,
                             logic [23:0] fill);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 13) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_func = func; s_ax = ax; s_ay = ay; s_bx = bx; s_by_coord = by;
        s_cx = cx; s_cy = cy; s_fill_color = fill; s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        scan_sb.note_beat(func, ax, ay, bx, by, cx, cy, fill);
        beats_sent++;
        no_idle = beats_sent > 600 && beats_sent < 900;
    endtask

    task automatic load(logic [9:0] ax, logic [9:0] ay, logic [9:0] bx, logic [9:0] by,
                        logic [9:0] cx, logic [9:0] cy, logic [23:0] fill);
        send_beat(FUNC_LOAD, ax, ay, bx, by, cx, cy, fill);
    endtask

    task automatic step(int n);
        repeat (n) send_beat(FUNC_STEP, 10'($urandom), 10'($urandom), 10'($urandom),
                             10'($urandom), 10'($urandom), 10'($urandom),
                             24'($urandom));
    endtask

    task automatic drain_triangle(int extra);
        while (scan_sb.pending) step(1);
        step(extra);
    endtask

    initial begin
        int base_x, base_y, span, limit;
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn = 1;

        // step with nothing loaded
        step(2);
        // flat triangle, all on one row
        load(10, 5, 20, 5, 30, 5, 24'hffffff);
        step(1);
        // flat bottom and flat top, small
        load(0, 0, 4, 0, 2, 3, 24'h123456);
        drain_triangle(1);
        load(1023, 1020, 1019, 1023, 1023, 1023, 24'hfedcba);
        drain_triangle(1);
        // load while pending, then extreme corners
        load(3, 1, 0, 6, 7, 5, 24'h00ff00);
        step(2);
        load(0, 0, 1023, 0, 0, 1023, 24'h000000);
        step(3);
        load(1023, 0, 0, 1023, 1023, 1023, 24'h800001);
        step(2);
        // long edge on the left
        load(2, 0, 8, 3, 0, 7, 24'haaaaaa);
        step(4);

        while (beats_sent < 1550) begin
            if ($urandom_range(14) == 0) begin
                load(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                     10'($urandom), 10'($urandom), 24'($urandom));
                step($urandom_range(1, 6));
            end else begin
                span = $urandom_range(1, 24);
                base_x = $urandom_range(0, 1023 - span);
                base_y = $urandom_range(0, 1023 - span);
                load(10'(base_x + $urandom_range(0, span)), 10'(base_y + $urandom_range(0, span)),
                     10'(base_x + $urandom_range(0, span)), 10'(base_y + $urandom_range(0, span)),
                     10'(base_x + $urandom_range(0, span)), 10'(base_y + $urandom_range(0, span)),
                     24'($urandom));
                if ($urandom_range(9) < 6) begin
                    drain_triangle($urandom_range(0, 2));
                end else begin
                    limit = $urandom_range(1, 40);
                    step(limit);
                end
            end
        end

        @(negedge aclk) s_valid = 0;
        while (scan_sb.due_pixels.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (scan_sb.due_pixels.size() == 0 && scan_sb.mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
